// File: src/bdwc_pkg.sv
// shared types, constants and encode functions of the bitmask dictionary compressor
package bdwc_pkg;

	localparam int WORD_W      = 32;
	localparam int DICT_N      = 8;
	localparam int IDX_W       = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int CNT_W       = 3;
	localparam int CODE_W      = 35;
	localparam int LEN_W       = 6;
	localparam int KIND_W      = 3;
	localparam int JOBQ_DEPTH  = 4;
	localparam int JOBQ_AW     = 2;
	localparam int JOBQ_CNT_W  = 3;

	localparam logic [CNT_W-1:0] MAX_REPEATS = 3'd4;

	// code prefixes
	localparam logic [2:0] PFX_REPEAT  = 3'b000;
	localparam logic [2:0] PFX_DIRECT  = 3'b101;
	localparam logic [2:0] PFX_ONE     = 3'b010;
	localparam logic [2:0] PFX_CONSEC  = 3'b011;
	localparam logic [2:0] PFX_BITMASK = 3'b001;
	localparam logic [2:0] PFX_TWO     = 3'b100;
	localparam logic [2:0] PFX_RAW     = 3'b111;

	// code kinds
	localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DIRECT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ONE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONSEC  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BITMASK = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TWO     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RAW     = 3'd6;

	// code lengths
	localparam logic [LEN_W-1:0] LEN_REPEAT  = 6'd5;
	localparam logic [LEN_W-1:0] LEN_DIRECT  = 6'd6;
	localparam logic [LEN_W-1:0] LEN_ONE     = 6'd11;
	localparam logic [LEN_W-1:0] LEN_CONSEC  = 6'd11;
	localparam logic [LEN_W-1:0] LEN_BITMASK = 6'd15;
	localparam logic [LEN_W-1:0] LEN_TWO     = 6'd16;
	localparam logic [LEN_W-1:0] LEN_RAW     = 6'd35;

	typedef logic [DICT_N-1:0][WORD_W-1:0] dict_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              final_word;
	} in_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic [KIND_W-1:0] code_kind;
		logic              run_end;
	} out_t;

	// one queue entry: first word to encode, optional second word
	typedef struct packed {
		logic [WORD_W-1:0] word0;
		logic [CNT_W-1:0]  count0;
		logic              has1;
		logic [WORD_W-1:0] word1;
		logic [CNT_W-1:0]  count1;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CODE0,
		ST_REP0,
		ST_CODE1,
		ST_REP1
	} bk_state_t;

	function automatic out_t bdwc_repeat(input logic [CNT_W-1:0] cnt);
		out_t r;
		logic [CNT_W-1:0] m1;
		m1            = cnt - 3'd1;
		r.code_bits   = {30'b0, PFX_REPEAT, m1[1:0]};
		r.code_length = LEN_REPEAT;
		r.code_kind   = KIND_REPEAT;
		r.run_end     = 1'b0;
		return r;
	endfunction

	// classify a word against the dictionary and build its code
	function automatic out_t bdwc_encode(input logic [WORD_W-1:0] w, input dict_t dict);
		out_t r;
		logic [DICT_N-1:0][WORD_W-1:0] d_a;
		logic [DICT_N-1:0][4:0] lo_a;
		logic [DICT_N-1:0][4:0] hi_a;
		logic [DICT_N-1:0] f_dir, f_one, f_con, f_bm, f_two;
		logic [WORD_W-1:0] dm1, x, xm1, dsel;
		logic [4:0] span, hsel;
		logic [3:0] mask;
		logic fd_dir, fd_one, fd_con, fd_bm, fd_two;
		logic [IDX_W-1:0] ix_dir, ix_one, ix_con, ix_bm, ix_two;
		d_a = '0;
		lo_a = '0;
		hi_a = '0;
		f_dir = '0;
		f_one = '0;
		f_con = '0;
		f_bm = '0;
		f_two = '0;
		for (int i = 0; i < DICT_N; i++) begin
			d_a[i] = dict[i] ^ w;
			for (int p = WORD_W-1; p >= 0; p--) begin
				if (d_a[i][p]) begin
					lo_a[i] = 5'(p);
				end
			end
			for (int p = 0; p < WORD_W; p++) begin
				if (d_a[i][p]) begin
					hi_a[i] = 5'(p);
				end
			end
			dm1 = d_a[i] - 32'd1;
			x = d_a[i] & dm1;
			xm1 = x - 32'd1;
			span = hi_a[i] - lo_a[i];
			f_dir[i] = (d_a[i] == '0);
			f_one[i] = (d_a[i] != '0) && (x == '0);
			f_two[i] = (x != '0) && ((x & xm1) == '0);
			f_con[i] = f_two[i] && (hi_a[i] == lo_a[i] + 5'd1);
			f_bm[i]  = (d_a[i] != '0) && (span < 5'd4);
		end
		fd_dir = 1'b0; fd_one = 1'b0; fd_con = 1'b0; fd_bm = 1'b0; fd_two = 1'b0;
		ix_dir = '0; ix_one = '0; ix_con = '0; ix_bm = '0; ix_two = '0;
		// lowest index wins: scan downward and overwrite
		for (int i = DICT_N-1; i >= 0; i--) begin
			if (f_dir[i]) begin fd_dir = 1'b1; ix_dir = IDX_W'(i); end
			if (f_one[i]) begin fd_one = 1'b1; ix_one = IDX_W'(i); end
			if (f_con[i]) begin fd_con = 1'b1; ix_con = IDX_W'(i); end
			if (f_bm[i])  begin fd_bm  = 1'b1; ix_bm  = IDX_W'(i); end
			if (f_two[i]) begin fd_two = 1'b1; ix_two = IDX_W'(i); end
		end
		dsel = d_a[ix_bm];
		hsel = hi_a[ix_bm];
		if (hsel >= 5'd3) begin
			mask = 4'(dsel >> (hsel - 5'd3));
		end else begin
			mask = 4'(dsel << (5'd3 - hsel));
		end
		r.run_end = 1'b0;
		// a location is 31 minus the bit position, which is the inverted 5-bit position
		if (fd_dir) begin
			r.code_bits   = {29'b0, PFX_DIRECT, ix_dir};
			r.code_length = LEN_DIRECT;
			r.code_kind   = KIND_DIRECT;
		end else if (fd_one) begin
			r.code_bits   = {24'b0, PFX_ONE, ~lo_a[ix_one], ix_one};
			r.code_length = LEN_ONE;
			r.code_kind   = KIND_ONE;
		end else if (fd_con) begin
			r.code_bits   = {24'b0, PFX_CONSEC, ~hi_a[ix_con], ix_con};
			r.code_length = LEN_CONSEC;
			r.code_kind   = KIND_CONSEC;
		end else if (fd_bm) begin
			r.code_bits   = {20'b0, PFX_BITMASK, ~hsel, mask, ix_bm};
			r.code_length = LEN_BITMASK;
			r.code_kind   = KIND_BITMASK;
		end else if (fd_two) begin
			r.code_bits   = {19'b0, PFX_TWO, ~hi_a[ix_two], ~lo_a[ix_two], ix_two};
			r.code_length = LEN_TWO;
			r.code_kind   = KIND_TWO;
		end else begin
			r.code_bits   = {PFX_RAW, w};
			r.code_length = LEN_RAW;
			r.code_kind   = KIND_RAW;
		end
		return r;
	endfunction

endpackage

// File: src/bdwc_front.sv
// front end: takes words, merges runs and queues the words to be encoded
module bdwc_front import bdwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  in_item,
	output logic full,
	input  logic jq_full,
	output logic jq_push,
	output job_t jq_wr
);

	logic [WORD_W-1:0] pending_word_q;
	logic              pending_valid_q;
	logic [CNT_W-1:0]  repeat_count_q;

	logic              accept;
	logic              merge;
	logic              emit_old;
	logic [WORD_W-1:0] new_word;
	logic [CNT_W-1:0]  new_count;

	assign full   = jq_full;
	assign accept = push && !jq_full;

	always_comb begin
		merge    = pending_valid_q && (in_item.data_word == pending_word_q) &&
		           (repeat_count_q < MAX_REPEATS);
		emit_old = pending_valid_q && !merge;
		if (merge) begin
			new_word  = pending_word_q;
			new_count = repeat_count_q + 3'd1;
		end else begin
			new_word  = in_item.data_word;
			new_count = '0;
		end
		jq_push = accept && (emit_old || in_item.final_word);
		if (emit_old) begin
			jq_wr.word0  = pending_word_q;
			jq_wr.count0 = repeat_count_q;
			jq_wr.has1   = in_item.final_word;
		end else begin
			jq_wr.word0  = new_word;
			jq_wr.count0 = new_count;
			jq_wr.has1   = 1'b0;
		end
		jq_wr.word1  = new_word;
		jq_wr.count1 = new_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_word_q  <= '0;
			pending_valid_q <= 1'b0;
			repeat_count_q  <= '0;
		end else if (accept) begin
			if (in_item.final_word) begin
				pending_word_q  <= '0;
				pending_valid_q <= 1'b0;
				repeat_count_q  <= '0;
			end else begin
				pending_word_q  <= new_word;
				pending_valid_q <= 1'b1;
				repeat_count_q  <= new_count;
			end
		end
	end

endmodule

// File: src/bdwc_job_fifo.sv
// short queue of encode jobs between the front end and the encoder
module bdwc_job_fifo import bdwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t rd_job,
	output logic empty
);

	job_t                  mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0]    wr_ptr_q;
	logic [JOBQ_AW-1:0]    rd_ptr_q;
	logic [JOBQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == JOBQ_CNT_W'(JOBQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/bdwc_back.sv
// back end: encodes queued words and emits codes and repeat codes into the result register
module bdwc_back import bdwc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  dict_t dict,
	input  logic  jq_empty,
	input  job_t  jq_rd,
	output logic  jq_pop,
	output logic  empty,
	input  logic  pop,
	output out_t  out_item
);

	bk_state_t state_q, state_d;
	job_t      cur_q;
	logic      out_valid_q;
	out_t      out_q;

	logic      out_free;
	logic      emit;
	logic      last;
	logic      load;
	out_t      res;
	out_t      enc;
	logic [WORD_W-1:0] enc_word;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	assign enc_word = (state_q == ST_CODE1) ? cur_q.word1 : cur_q.word0;
	assign enc      = bdwc_encode(enc_word, dict);

	// outputs of the sequencer
	always_comb begin
		emit = 1'b0;
		last = 1'b0;
		res  = enc;
		case (state_q)
			ST_IDLE: begin
				emit = 1'b0;
			end
			ST_CODE0: begin
				emit = out_free;
				last = (cur_q.count0 == '0) && !cur_q.has1;
			end
			ST_REP0: begin
				emit = out_free;
				res  = bdwc_repeat(cur_q.count0);
				last = !cur_q.has1;
			end
			ST_CODE1: begin
				emit = out_free;
				last = (cur_q.count1 == '0);
			end
			ST_REP1: begin
				emit = out_free;
				res  = bdwc_repeat(cur_q.count1);
				last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		res.run_end = last;
		load   = ((state_q == ST_IDLE) || (emit && last)) && !jq_empty;
		jq_pop = load;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (load) begin
					state_d = ST_CODE0;
				end
			end
			ST_CODE0, ST_REP0, ST_CODE1, ST_REP1: begin
				if (emit) begin
					if (last) begin
						state_d = load ? ST_CODE0 : ST_IDLE;
					end else begin
						case (state_q)
							ST_CODE0: state_d = (cur_q.count0 != '0) ? ST_REP0 : ST_CODE1;
							ST_REP0:  state_d = ST_CODE1;
							ST_CODE1: state_d = ST_REP1;
							default:  state_d = ST_IDLE;
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= jq_rd;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

// File: src/bitmask_dictionary_word_compressor_top.sv
// top level of the bitmask dictionary word compressor: dictionary registers and block wiring
//
// Compresses a stream of 32-bit words against an eight-word dictionary written through the
// cfg port (indexes 0 to 7, writes at higher indexes are dropped; all entries reset to zero).
// Equal words in a row merge into runs of up to four repeats; each emitted word yields its
// code (direct, one-bit, two-consecutive, bitmask, two-anywhere or raw) and, for a nonzero
// run, a repeat code, and a word with final_word set flushes what is pending, so one input
// word causes zero to three results, run_end marking the last. A word is taken in every
// cycle while the four-entry job queue between the front end and the encoder has room; the
// encoder sequencer sends out one result per cycle, while the output register is free, into a
// single output register, so the sustained input rate is one word per cycle when the
// stream compresses into runs and falls to the encoder's one result per cycle otherwise.
// The dictionary compare and code selection are combinational. No clearing pass follows reset.
module bitmask_dictionary_word_compressor_top import bdwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  in_t                  in_item,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output out_t                 out_item,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	dict_t dict_q;
	logic  jq_push;
	job_t  jq_wr;
	logic  jq_full;
	logic  jq_pop;
	job_t  jq_rd;
	logic  jq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= '0;
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(DICT_N))) begin
			dict_q[cfg_index[IDX_W-1:0]] <= cfg_data;
		end
	end

	bdwc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.full    (full),
		.jq_full (jq_full),
		.jq_push (jq_push),
		.jq_wr   (jq_wr)
	);

	bdwc_job_fifo u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wr_job (jq_wr),
		.full   (jq_full),
		.pop    (jq_pop),
		.rd_job (jq_rd),
		.empty  (jq_empty)
	);

	bdwc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dict     (dict_q),
		.jq_empty (jq_empty),
		.jq_rd    (jq_rd),
		.jq_pop   (jq_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

// File: tb/sv/code_stream_checker.sv
// checker for the word compressor: predicts the codes of each accepted word and compares them
module code_stream_checker import bdwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  in_t                  in_item,
	input  logic                 pop,
	input  logic                 empty,
	input  out_t                 out_item,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output int                   due_count,
	output int                   fail_count,
	output int                   code_count
);

	logic [WORD_W-1:0] dict_copy [DICT_N];
	logic [WORD_W-1:0] held_word;
	logic              held_valid;
	logic [CNT_W-1:0]  held_reps;
	out_t              due_codes [$];
	int                fails;
	int                checked;

	// code of one word against the current dictionary; each test runs over all entries
	// before the next test is tried
	function automatic out_t word_code(input logic [WORD_W-1:0] w);
		out_t              c;
		logic [WORD_W-1:0] diff [DICT_N];
		int                ones [DICT_N];
		int                lo [DICT_N];
		int                hi [DICT_N];
		logic [3:0]        mask;
		int                pick;
		c = '0;
		pick = -1;
		for (int i = 0; i < DICT_N; i++) begin
			diff[i] = dict_copy[i] ^ w;
			ones[i] = $countones(diff[i]);
			lo[i] = 31;
			hi[i] = 0;
			for (int p = 0; p < WORD_W; p++) begin
				if (diff[i][p]) begin
					hi[i] = p;
				end
			end
			for (int p = 0; p < WORD_W; p++) begin
				if (diff[i][WORD_W-1-p]) begin
					lo[i] = WORD_W-1-p;
				end
			end
		end
		for (int i = 0; i < DICT_N; i++) begin
			if (pick < 0 && ones[i] == 0) begin
				pick = i;
				c.code_bits = {29'b0, PFX_DIRECT, IDX_W'(i)};
				c.code_length = LEN_DIRECT;
				c.code_kind = KIND_DIRECT;
			end
		end
		for (int i = 0; i < DICT_N; i++) begin
			if (pick < 0 && ones[i] == 1) begin
				pick = i;
				c.code_bits = {24'b0, PFX_ONE, 5'(31 - lo[i]), IDX_W'(i)};
				c.code_length = LEN_ONE;
				c.code_kind = KIND_ONE;
			end
		end
		for (int i = 0; i < DICT_N; i++) begin
			if (pick < 0 && ones[i] == 2 && hi[i] == lo[i] + 1) begin
				pick = i;
				c.code_bits = {24'b0, PFX_CONSEC, 5'(31 - hi[i]), IDX_W'(i)};
				c.code_length = LEN_CONSEC;
				c.code_kind = KIND_CONSEC;
			end
		end
		for (int i = 0; i < DICT_N; i++) begin
			if (pick < 0 && ones[i] >= 1 && ones[i] <= 4 && hi[i] - lo[i] < 4) begin
				pick = i;
				// mask window starts at the highest differing bit, zero-filled below bit 0
				if (hi[i] >= 3) begin
					mask = 4'(diff[i] >> (hi[i] - 3));
				end else begin
					mask = 4'(diff[i] << (3 - hi[i]));
				end
				c.code_bits = {20'b0, PFX_BITMASK, 5'(31 - hi[i]), mask, IDX_W'(i)};
				c.code_length = LEN_BITMASK;
				c.code_kind = KIND_BITMASK;
			end
		end
		for (int i = 0; i < DICT_N; i++) begin
			if (pick < 0 && ones[i] == 2) begin
				pick = i;
				c.code_bits = {19'b0, PFX_TWO, 5'(31 - hi[i]), 5'(31 - lo[i]), IDX_W'(i)};
				c.code_length = LEN_TWO;
				c.code_kind = KIND_TWO;
			end
		end
		if (pick < 0) begin
			c.code_bits = {PFX_RAW, w};
			c.code_length = LEN_RAW;
			c.code_kind = KIND_RAW;
		end
		return c;
	endfunction

	// the held word's code, then its repeat code for a nonzero run
	function automatic void emit_run();
		out_t rep;
		due_codes.insert(due_codes.size(), word_code(held_word));
		if (held_reps != '0) begin
			rep = '0;
			rep.code_bits = {30'b0, PFX_REPEAT, 2'(held_reps - 1'b1)};
			rep.code_length = LEN_REPEAT;
			rep.code_kind = KIND_REPEAT;
			due_codes.insert(due_codes.size(), rep);
		end
	endfunction

	function automatic void take_word(input in_t it);
		int   first;
		out_t last;
		first = due_codes.size();
		if (!held_valid) begin
			held_word = it.data_word;
			held_valid = 1'b1;
			held_reps = '0;
		end else if (it.data_word == held_word && held_reps < MAX_REPEATS) begin
			held_reps = held_reps + 1'b1;
		end else begin
			emit_run();
			held_word = it.data_word;
			held_reps = '0;
		end
		if (it.final_word) begin
			emit_run();
			held_word = '0;
			held_valid = 1'b0;
			held_reps = '0;
		end
		if (due_codes.size() > first) begin
			last = due_codes[due_codes.size() - 1];
			last.run_end = 1'b1;
			due_codes[due_codes.size() - 1] = last;
		end
	endfunction

	function automatic void check_code(input out_t got);
		out_t want;
		checked++;
		if (due_codes.size() == 0) begin
			$error("code with no word to account for it: bits %h kind %0d",
				got.code_bits, got.code_kind);
			fails++;
			return;
		end
		want = due_codes.pop_front();
		if (got.code_bits !== want.code_bits) begin
			$error("code_bits: expected %h, got %h", want.code_bits, got.code_bits);
			fails++;
		end
		if (got.code_length !== want.code_length) begin
			$error("code_length: expected %0d, got %0d", want.code_length, got.code_length);
			fails++;
		end
		if (got.code_kind !== want.code_kind) begin
			$error("code_kind: expected %0d, got %0d", want.code_kind, got.code_kind);
			fails++;
		end
		if (got.run_end !== want.run_end) begin
			$error("run_end: expected %b, got %b", want.run_end, got.run_end);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DICT_N; i++) begin
				dict_copy[i] = '0;
			end
			held_word = '0;
			held_valid = 1'b0;
			held_reps = '0;
			due_codes.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (cfg_wr_en && cfg_index < DICT_N) begin
				dict_copy[cfg_index] = cfg_data;
			end
			if (push && !full) begin
				take_word(in_item);
			end
			if (pop && !empty) begin
				check_code(out_item);
			end
		end
		due_count <= due_codes.size();
		fail_count <= fails;
		code_count <= checked;
	end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for the word compressor: reset, dictionary setup, word stream and verdict
module tb_top import bdwc_pkg::*; ();

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	in_t                  in_item = '0;
	logic                 full;
	logic                 empty;
	logic                 pop = 1'b0;
	out_t                 out_item;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	int                   due_count;
	int                   fail_count;
	int                   code_count;

	logic [WORD_W-1:0]    dict_now [DICT_N];
	logic                 calm = 1'b0;
	int                   n_sent = 0;
	int                   n_dicts = 0;
	int                   quiet = 0;

	bitmask_dictionary_word_compressor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	code_stream_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.pop        (pop),
		.empty      (empty),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.due_count  (due_count),
		.fail_count (fail_count),
		.code_count (code_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(0, 99) >= 30);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet == QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w, input logic fin);
		while (!calm && $urandom_range(0, 99) < 30) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_item <= '{data_word: w, final_word: fin};
		do begin
			@(posedge clk);
		end while (full !== 1'b0);
		n_sent++;
	endtask

	// sender holds off until every predicted code has come out
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (due_count != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// loads dict_now, then one write outside the dictionary that must be dropped
	task automatic write_dict();
		for (int i = 0; i < DICT_N; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= dict_now[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IDX_W'(DICT_N + $urandom_range(0, 7));
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_dicts++;
	endtask

	// a dictionary word with a few bits flipped, or anything at all
	function automatic logic [WORD_W-1:0] near_word();
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] flip;
		int                a;
		int                b;
		base = dict_now[$urandom_range(0, DICT_N-1)];
		a = $urandom_range(0, 31);
		b = $urandom_range(0, 31);
		case ($urandom_range(0, 7))
			0: begin
				flip = '0;
			end
			1: begin
				flip = 32'd1 << a;
			end
			2: begin
				flip = 32'd3 << $urandom_range(0, 30);
			end
			3: begin
				flip = 32'($urandom_range(1, 15)) << $urandom_range(0, 28);
			end
			4: begin
				flip = (32'd1 << a) | (32'd1 << b);
			end
			5: begin
				flip = $urandom & $urandom & $urandom;
			end
			default: begin
				flip = $urandom;
			end
		endcase
		return base ^ flip;
	endfunction

	// runs of equal words with random length, occasional flush, last word always final
	task automatic stream_phase(input int budget, input logic hold_mid);
		logic [WORD_W-1:0] w;
		int                len;
		int                n;
		logic              fin;
		n = 0;
		while (n < budget) begin
			w = near_word();
			len = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 7);
			for (int k = 0; k < len && n < budget; k++) begin
				fin = ($urandom_range(0, 99) < 6) || (n == budget - 1);
				send_word(w, fin);
				n++;
				if (hold_mid && n == budget / 2) begin
					wait_drained();
				end
			end
		end
	endtask

	initial begin
		logic [WORD_W-1:0] base;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dict_now[0] = 32'h0000_0000;
		dict_now[1] = 32'hFFFF_FFFF;
		dict_now[2] = 32'h1234_5678;
		dict_now[3] = 32'hA5A5_5A5A;
		dict_now[4] = 32'h8000_0001;
		dict_now[5] = 32'h0F0F_F0F0;
		dict_now[6] = 32'hDEAD_BEEF;
		dict_now[7] = 32'h7FFF_FFFE;
		write_dict();

		// full run of five, then a sixth equal word starts a fresh run
		repeat (6) send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h1234_5678 ^ 32'h8000_0000, 1'b0);
		send_word(32'h1234_5678 ^ 32'h0000_0001, 1'b0);
		send_word(32'hA5A5_5A5A ^ 32'hC000_0000, 1'b0);
		send_word(32'hA5A5_5A5A ^ 32'h0000_0009, 1'b0);
		send_word(32'hA5A5_5A5A ^ 32'h0000_00F0, 1'b0);
		send_word(32'h8000_0001 ^ 32'h0000_0005, 1'b0);
		send_word(32'h0F0F_F0F0 ^ 32'h8000_0001, 1'b0);
		send_word(32'h3C3C_1111, 1'b0);
		send_word(32'h3C3C_1111, 1'b1);
		// final word with nothing held
		send_word(32'h7FFF_FFFE, 1'b1);
		// held run plus a different final word gives three codes
		send_word(32'hDEAD_BEEF, 1'b0);
		send_word(32'hDEAD_BEEF, 1'b0);
		send_word(32'h0000_0001, 1'b1);
		// full run flushed by its own final word
		repeat (4) send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		settle();

		for (int i = 0; i < DICT_N; i++) begin
			dict_now[i] = $urandom;
		end
		write_dict();
		calm = 1'b1;
		stream_phase(60, 1'b0);
		settle();
		calm = 1'b0;

		for (int i = 0; i < DICT_N; i++) begin
			dict_now[i] = '0;
		end
		write_dict();
		stream_phase(60, 1'b0);
		settle();

		for (int i = 0; i < DICT_N; i++) begin
			dict_now[i] = '1;
		end
		write_dict();
		stream_phase(60, 1'b1);
		settle();

		// close entries and duplicates so the lowest index has to win
		base = $urandom;
		for (int i = 0; i < DICT_N; i++) begin
			dict_now[i] = (i % 3 == 0) ? base : base ^ ($urandom & $urandom & $urandom);
		end
		write_dict();
		stream_phase(70, 1'b0);
		settle();

		$display("covered %0d words over %0d dictionaries, %0d codes compared",
			n_sent, n_dicts, code_count);
		$display("directed code kinds and run limits, then random runs with idle and stall");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
